[sv/chs_pkg.sv]
`timescale 1ns / 1ps

package chs_pkg;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FULL = 1'b1
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_CHK,
        S_NODE,
        S_RESP
    } state_t;

endpackage

[sv/chained_hash_set.sv]
`timescale 1ns / 1ps

// Hash set with separate chaining over a fixed node pool.
// Input item: s_tuser = mode (0 insert, 1 look up), s_tdata = key.
// Result item: m_tdata[0] = found, m_tuser = status (1: insert refused, pool full).
// One result per input item, in order. Inserts do not check for duplicates;
// a lookup walks the key's bucket chain one node per cycle through the node
// memory's single read port.
// After acceptance: S_MOD (key remainder), S_CHK (bucket head read; an insert writes
// its node), S_NODE once per node for a lookup with a non-empty chain, then S_RESP.
// If BUCKETS is no power of two, S_MOD waits longer for a reciprocal multiply.
// s_tready is high only while the sequencer is idle, so one item is in work
// at a time and the next may be accepted in the cycle the result appears.
// The result sits in an output register; a stalled receiver holds it and
// the next item's result waits in the sequencer until the register frees.
// After reset the bucket heads are cleared one per cycle, with s_tready low
// until all are clear. The pool then starts empty.
module chained_hash_set #(
    parameter int BUCKETS    = 16,
    parameter int POOL_NODES = 64,
    parameter int KEY_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((KEY_BITS + 7) / 8) * 8-1:0]  s_tdata,  // key
    input  logic                                 s_tuser,  // mode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,  // found
    output logic                                 m_tuser   // status
);

    import chs_pkg::*;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int REF_W   = $clog2(POOL_NODES + 1);
    localparam int NODE_DW = KEY_BITS + REF_W;

    state_t              state_reg, state_next;
    logic [BKT_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [REF_W-1:0]    nodes_used_reg, nodes_used_next;
    mode_t               mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                res_found_reg, res_found_next;
    status_t             res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_found_reg;
    status_t             out_status_reg;
    logic                out_load;

    logic                accept;
    logic                mod_done;
    logic [BKT_W-1:0]    bucket;

    logic [REF_W-1:0]    head_mem [BUCKETS];
    logic [REF_W-1:0]    head_rd_reg;
    logic                head_we;
    logic [BKT_W-1:0]    head_waddr;
    logic [REF_W-1:0]    head_wdata;

    logic [NODE_DW-1:0]  node_mem [POOL_NODES];
    logic [NODE_DW-1:0]  node_rd_reg;
    logic                node_we;
    logic [REF_W-1:0]    ref_sel;
    logic [REF_W-1:0]    ref_dec;
    logic [NODE_W-1:0]   node_raddr;
    logic [KEY_BITS-1:0] node_key;
    logic [REF_W-1:0]    node_link;
    logic                pool_full;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'b0, out_found_reg};
    assign m_tuser   = out_status_reg;

    assign node_key  = node_rd_reg[NODE_DW-1 -: KEY_BITS];
    assign node_link = node_rd_reg[REF_W-1:0];
    assign pool_full = (nodes_used_reg == REF_W'(POOL_NODES));

    // node refs are index + 1; zero ends a chain
    assign ref_sel    = (state_reg == S_CHK) ? head_rd_reg : node_link;
    assign ref_dec    = ref_sel - REF_W'(1);
    assign node_raddr = ref_dec[NODE_W-1:0];

    chs_mod #(
        .KEY_BITS (KEY_BITS),
        .BUCKETS  (BUCKETS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key_in  (s_tdata[KEY_BITS-1:0]),
        .done    (mod_done),
        .rem     (bucket)
    );

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[bucket];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[nodes_used_reg[NODE_W-1:0]] <= {key_reg, head_rd_reg};
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nodes_used_next = nodes_used_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        head_we         = 1'b0;
        head_waddr      = bucket;
        head_wdata      = nodes_used_reg + REF_W'(1);
        node_we         = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_cnt_reg;
                head_wdata = '0;
                clr_cnt_next = clr_cnt_reg + BKT_W'(1);
                if (clr_cnt_reg == BKT_W'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                res_found_next  = 1'b0;
                res_status_next = ST_OK;
                if (mode_reg == MODE_INSERT) begin
                    state_next = S_RESP;
                    if (pool_full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        node_we         = 1'b1;
                        head_we         = 1'b1;
                        nodes_used_next = nodes_used_reg + REF_W'(1);
                    end
                end else if (head_rd_reg == '0) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_NODE;
                end
            end
            S_NODE: begin
                if (node_key == key_reg) begin
                    res_found_next = 1'b1;
                    state_next     = S_RESP;
                end else if (node_link == '0) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            nodes_used_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            nodes_used_reg <= nodes_used_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_t'(s_tuser);
            key_reg  <= s_tdata[KEY_BITS-1:0];
        end
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
        end
    end

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg <= REF_W'(POOL_NODES))
        else $error("node count beyond pool size");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_refuse_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (res_status_reg == ST_FULL) |-> pool_full && !res_found_reg)
        else $error("insert refused with free nodes left");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready && !m_tvalid_reg)
        else $error("activity during bucket clearing");

endmodule

[sv/chs_mod.sv]
`timescale 1ns / 1ps

// Key modulo BUCKETS: a mask for a power of two, otherwise a reciprocal
// multiply for the quotient and a multiply-back and subtract on the registered product.
module chs_mod #(
    parameter int KEY_BITS = 16,
    parameter int BUCKETS  = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [KEY_BITS-1:0]        key_in,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] rem
);

    localparam int  BKT_W   = $clog2(BUCKETS);
    localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int  EXT_W   = (KEY_BITS > BKT_W) ? KEY_BITS : BKT_W;

    logic             done_reg;
    logic [BKT_W-1:0] rem_reg;
    logic [EXT_W-1:0] key_ext;

    assign done    = done_reg;
    assign rem     = rem_reg;
    assign key_ext = EXT_W'(key_in);

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    rem_reg <= key_ext[BKT_W-1:0];
                end
            end
        end else begin : g_rcp
            // rounded-up reciprocal: the quotient is exact for every key value while SH stays below 64
            localparam int SH     = EXT_W + BKT_W;
            localparam int RCP_W  = EXT_W + 1;
            localparam int PROD_W = EXT_W + RCP_W;
            localparam int QUO_W  = PROD_W - SH;
            localparam logic [RCP_W-1:0] RCP =
                RCP_W'(((64'd1 << SH) / 64'(BUCKETS)) + 64'd1);

            logic                busy_reg;
            logic [EXT_W-1:0]    key_reg;
            logic [PROD_W-1:0]   prod_reg;
            logic [QUO_W-1:0]    quot;
            logic [EXT_W-1:0]    back;
            logic [EXT_W-1:0]    diff;

            assign quot = prod_reg[PROD_W-1:SH];
            assign back = EXT_W'(quot) * EXT_W'(BUCKETS);
            assign diff = key_reg - back;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    busy_reg <= start;
                    done_reg <= busy_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    key_reg  <= key_ext;
                    prod_reg <= PROD_W'(key_ext) * PROD_W'(RCP);
                end
                if (busy_reg) begin
                    rem_reg <= diff[BKT_W-1:0];
                end
            end
        end
    endgenerate

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import chs_pkg::*;

    localparam int BUCKETS     = 16;
    localparam int POOL_NODES  = 64;
    localparam int KEY_BITS    = 16;
    localparam int RAND_ITEMS  = 1930;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;   // longest walk plus pipeline, rounded up
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_FROM  = 1000;
    localparam int QUIET_TO    = 1300;

    typedef struct packed {
        logic    found;
        status_t status;
    } set_reply_t;

    typedef struct packed {
        mode_t         mode;
        logic [15:0]   key;
        logic          typed;   // expected reply written out below
        logic          found;
        status_t       status;
    } probe_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    // shadow copy of the set
    logic [6:0]  shadow_head [BUCKETS];
    logic [15:0] shadow_key  [POOL_NODES];
    logic [6:0]  shadow_link [POOL_NODES];
    int          shadow_used;

    set_reply_t  expected_replies [$];
    logic [15:0] stored_keys [$];
    int          items_sent   = 0;
    int          results_seen = 0;
    int          errors       = 0;
    int          cycles       = 0;
    int          hold_left    = 0;
    bit          hold_done    = 0;

    // directed items; expected replies typed in only where obvious
    probe_row_t probe_rows [0:21] = '{
        '{MODE_LOOKUP, 16'h0000, 1'b1, 1'b0, ST_OK},   // empty set after reset
        '{MODE_LOOKUP, 16'hFFFF, 1'b1, 1'b0, ST_OK},
        '{MODE_INSERT, 16'h0000, 1'b1, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h0000, 1'b1, 1'b1, ST_OK},
        '{MODE_INSERT, 16'hFFFF, 1'b1, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'hFFFF, 1'b1, 1'b1, ST_OK},
        '{MODE_LOOKUP, 16'h000F, 1'b1, 1'b0, ST_OK},   // same bucket, other key
        '{MODE_INSERT, 16'h0010, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT, 16'h0000, 1'b0, 1'b0, ST_OK},   // duplicate goes in anyway
        '{MODE_LOOKUP, 16'h0000, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h0010, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h0020, 1'b0, 1'b0, ST_OK},   // miss after full walk
        '{MODE_INSERT, 16'h8000, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h0000, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT, 16'h5555, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT, 16'hAAAA, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h5555, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'hAAAA, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h5554, 1'b0, 1'b0, ST_OK},   // empty bucket
        '{MODE_INSERT, 16'h7FFF, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h7FFF, 1'b0, 1'b0, ST_OK},
        '{MODE_LOOKUP, 16'h1234, 1'b0, 1'b0, ST_OK}
    };

    chained_hash_set #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES),
        .KEY_BITS   (KEY_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
    endfunction

    // applies one item to the shadow set and returns the reply it gives
    function automatic set_reply_t hash_set_apply(mode_t mode, logic [15:0] key);
        set_reply_t  reply;
        logic [3:0]  bucket;
        logic [6:0]  ptr;
        int          steps;
        reply  = '{found: 1'b0, status: ST_OK};
        bucket = 4'(key % BUCKETS);
        if (mode == MODE_INSERT) begin
            if (shadow_used >= POOL_NODES) begin
                reply.status = ST_FULL;
            end else begin
                shadow_key[shadow_used]  = key;
                shadow_link[shadow_used] = shadow_head[bucket];
                shadow_head[bucket]      = 7'(shadow_used + 1);
                shadow_used++;
            end
        end else begin
            ptr   = shadow_head[bucket];
            steps = 0;
            while (ptr != 0 && steps < shadow_used && !reply.found) begin
                if (shadow_key[ptr - 1] == key)
                    reply.found = 1'b1;
                ptr = shadow_link[ptr - 1];
                steps++;
            end
        end
        return reply;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < 50)
            $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got,
                     want);
        errors++;
    endtask

    // offers one item and waits until it is taken
    task automatic push_item(mode_t mode, logic [15:0] key, bit typed, set_reply_t typed_reply);
        set_reply_t predicted;
        while (!quiet_window() && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= key;
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = hash_set_apply(mode, key);
        expected_replies.push_back(typed ? typed_reply : predicted);
        if (mode == MODE_INSERT && predicted.status == ST_OK)
            stored_keys.push_back(key);
        items_sent++;
    endtask

    task automatic take_reply();
        set_reply_t want;
        if (expected_replies.size() == 0) begin
            report_mismatch("unexpected item", int'(m_tdata), 0);
            return;
        end
        want = expected_replies.pop_front();
        if (m_tdata !== {7'b0, want.found})
            report_mismatch("found", int'(m_tdata), int'(want.found));
        if (m_tuser !== want.status)
            report_mismatch("status", int'(m_tuser), int'(want.status));
        results_seen++;
    endtask

    // receiver: checks results, stalls at random, and once holds off long enough
    // for the block to back up into its input
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                take_reply();
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_window() || ($urandom_range(99) >= 22);
            end
        end
    end

    initial begin
        mode_t       mode;
        logic [15:0] key;
        int          pick;
        int          insert_pct;

        foreach (shadow_head[i]) shadow_head[i] = '0;
        foreach (shadow_key[i]) shadow_key[i] = '0;
        foreach (shadow_link[i]) shadow_link[i] = '0;
        shadow_used = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_rows[i])
            push_item(probe_rows[i].mode, probe_rows[i].key, probe_rows[i].typed,
                      '{found: probe_rows[i].found, status: probe_rows[i].status});

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // fewer inserts once the pool is full; they are all refused then
            insert_pct = (shadow_used < POOL_NODES) ? 35 : 15;
            pick = $urandom_range(99);
            if ($urandom_range(99) < insert_pct) begin
                mode = MODE_INSERT;
                if (pick < 50 || stored_keys.size() == 0)
                    key = 16'($urandom);
                else if (pick < 80)
                    key = {12'($urandom), 4'h3};   // pile up one bucket
                else
                    key = stored_keys[$urandom_range(stored_keys.size() - 1)];
            end else begin
                mode = MODE_LOOKUP;
                if (pick < 25 || stored_keys.size() == 0)
                    key = 16'($urandom);
                else if (pick < 75)
                    key = stored_keys[$urandom_range(stored_keys.size() - 1)];
                else
                    // same bucket as a stored key, usually absent
                    key = stored_keys[$urandom_range(stored_keys.size() - 1)]
                          ^ (16'h0010 << $urandom_range(11));
            end
            push_item(mode, key, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
sv/chs_pkg.sv
sv/chs_mod.sv
sv/chained_hash_set.sv
verif/tb.sv
